// ----- hw/rtl/ctsr_pkg.sv -----
package ctsr_pkg;

  localparam int SLOT_COUNT   = 1024;
  localparam int TASK_ID_BITS = 10;

  localparam int SLOT_BITS = $clog2(SLOT_COUNT);
  localparam int CNT_W     = $clog2(SLOT_COUNT + 1);

  localparam int TID_W   = 10;
  localparam int EARLY_W = 10;
  localparam int DUR_W   = 11;
  localparam int START_W = 10;
  localparam int END_W   = 11;

  localparam logic REQ_PROBE   = 1'b0;
  localparam logic REQ_RESERVE = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [TID_W-1:0]   task_id;
    logic [EARLY_W-1:0] earliest_slot;
    logic [DUR_W-1:0]   duration;
  } ctsr_req_t;

  typedef struct packed {
    logic               found;
    logic [START_W-1:0] start_slot;
    logic [END_W-1:0]   end_slot;
  } ctsr_rsp_t;

  typedef struct packed {
    logic clear;
    logic step;
    logic free;
  } ctsr_run_ctl_t;

endpackage

// ----- hw/rtl/ctsr_slot_ram.sv -----
module ctsr_slot_ram (
  input  logic                              clk,
  input  logic                              we,
  input  logic [ctsr_pkg::SLOT_BITS-1:0]    waddr,
  input  logic [ctsr_pkg::TASK_ID_BITS-1:0] wdata,
  input  logic                              re,
  input  logic [ctsr_pkg::SLOT_BITS-1:0]    raddr,
  output logic [ctsr_pkg::TASK_ID_BITS-1:0] rdata
);
  import ctsr_pkg::*;

  logic [TASK_ID_BITS-1:0] mem [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/ctsr_run_unit.sv -----
module ctsr_run_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  ctsr_pkg::ctsr_run_ctl_t      ctl,
  input  logic [ctsr_pkg::DUR_W-1:0]   dur,
  output logic                         hit
);
  import ctsr_pkg::*;

  logic [DUR_W-1:0] run;
  logic [DUR_W-1:0] run_next;
  logic [DUR_W-1:0] run_inc;

  assign run_inc = run + DUR_W'(1);
  assign hit     = ctl.step && ctl.free && (run_inc == dur);

  always_comb begin
    run_next = run;
    if (ctl.clear) begin
      run_next = '0;
    end else if (ctl.step) begin
      run_next = ctl.free ? run_inc : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= '0;
    end else begin
      run <= run_next;
    end
  end

endmodule

// ----- hw/rtl/contiguous_time_slot_reserver.sv -----
// Sequence per item: accept in idle, scan slots from earliest_slot through
// the registered table read, fill each reserved slot with the task id
// (reserve hits only), then a done state. One item at a time.
// Slot table has separate read and write ports; one read or write per cycle.
// Reset clears the table with busy high; done has no stall.
module contiguous_time_slot_reserver (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  ctsr_pkg::ctsr_req_t req,
  output logic                busy,
  output logic                done,
  output ctsr_pkg::ctsr_rsp_t rsp
);
  import ctsr_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_FILL  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]           state, state_next;
  logic [CNT_W-1:0]     idx, idx_next;
  logic                 rd_pend, rd_pend_next;
  logic [SLOT_BITS-1:0] rd_idx, rd_idx_next;
  logic [SLOT_BITS-1:0] fill_addr, fill_addr_next;
  logic [SLOT_BITS-1:0] hit_idx, hit_idx_next;
  ctsr_req_t            cur, cur_next;
  ctsr_rsp_t            res, res_next;

  logic                    we, re;
  logic [SLOT_BITS-1:0]    waddr, raddr;
  logic [TASK_ID_BITS-1:0] wdata, rd_data;
  logic [TASK_ID_BITS-1:0] tid;
  logic [31:0]             tid_wide;
  logic [31:0]             early_wide;
  logic [31:0]             start_w;
  logic [31:0]             end_w;
  logic                    issue;
  logic                    hit;
  ctsr_run_ctl_t           run_ctl;

  ctsr_slot_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rd_data)
  );

  ctsr_run_unit u_run (
    .clk (clk),
    .rst (rst),
    .ctl (run_ctl),
    .dur (cur.duration),
    .hit (hit)
  );

  assign tid_wide   = 32'(cur.task_id);
  assign tid        = tid_wide[TASK_ID_BITS-1:0];
  assign early_wide = 32'(req.earliest_slot);
  assign start_w    = 32'(rd_idx) + 32'd1 - 32'(cur.duration);
  assign end_w      = 32'(rd_idx) + 32'd1;
  assign issue      = (idx < CNT_W'(SLOT_COUNT));

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_DONE);
  assign rsp  = res;

  always_comb begin
    state_next     = state;
    idx_next       = idx;
    rd_pend_next   = 1'b0;
    rd_idx_next    = rd_idx;
    fill_addr_next = fill_addr;
    hit_idx_next   = hit_idx;
    cur_next       = cur;
    res_next       = res;
    we             = 1'b0;
    waddr          = fill_addr;
    wdata          = '0;
    re             = 1'b0;
    raddr          = idx[SLOT_BITS-1:0];
    run_ctl        = '0;
    case (state)
      ST_CLEAR: begin
        we             = 1'b1;
        fill_addr_next = fill_addr + SLOT_BITS'(1);
        if (fill_addr == SLOT_BITS'(SLOT_COUNT - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cur_next      = req;
          res_next      = '0;
          run_ctl.clear = 1'b1;
          idx_next      = CNT_W'(req.earliest_slot);
          if (req.duration == '0 || early_wide >= 32'(SLOT_COUNT)) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        re           = issue;
        rd_pend_next = issue;
        rd_idx_next  = idx[SLOT_BITS-1:0];
        if (issue) begin
          idx_next = idx + CNT_W'(1);
        end
        if (rd_pend) begin
          run_ctl.step = 1'b1;
          run_ctl.free = (rd_data == '0);
          if (hit) begin
            hit_idx_next        = rd_idx;
            res_next.found      = 1'b1;
            res_next.start_slot = start_w[START_W-1:0];
            fill_addr_next      = start_w[SLOT_BITS-1:0];
            if (cur.req_type == REQ_RESERVE) begin
              res_next.end_slot = end_w[END_W-1:0];
              state_next        = ST_FILL;
            end else begin
              state_next = ST_DONE;
            end
          end else if (!issue) begin
            state_next = ST_DONE;
          end
        end
      end
      ST_FILL: begin
        we             = 1'b1;
        wdata          = tid;
        fill_addr_next = fill_addr + SLOT_BITS'(1);
        if (fill_addr == hit_idx) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      fill_addr <= '0;
      rd_pend   <= 1'b0;
    end else begin
      state     <= state_next;
      fill_addr <= fill_addr_next;
      rd_pend   <= rd_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    idx     <= idx_next;
    rd_idx  <= rd_idx_next;
    hit_idx <= hit_idx_next;
    cur     <= cur_next;
    res     <= res_next;
  end

`ifndef SYNTHESIS
  a_done_then_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("done not followed by idle");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !rsp.found) |-> (rsp.start_slot == '0 && rsp.end_slot == '0))
    else $error("not-found result carries nonzero slots");

  a_probe_no_end: assert property (@(posedge clk) disable iff (rst)
    (done && cur.req_type == REQ_PROBE) |-> (rsp.end_slot == '0))
    else $error("probe result carries an end slot");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE || state == ST_SCAN || state == ST_DONE) |-> !we)
    else $error("slot table written outside clear or fill");
`endif

endmodule

// ----- tb/contiguous_time_slot_reserver_tb.sv -----
module contiguous_time_slot_reserver_tb;
  import ctsr_pkg::*;

  localparam int IDLE_LIMIT = 4 * SLOT_COUNT + 2000;
  localparam int FIT_DEPTH  = 4;

  logic      clk;
  logic      rst;
  logic      start;
  ctsr_req_t req;
  logic      busy;
  logic      done;
  ctsr_rsp_t rsp;

  logic [TID_W-1:0] owner_map [SLOT_COUNT];
  ctsr_rsp_t        fit_ring [FIT_DEPTH];
  int               fit_head;
  int               fit_tail;
  int               mismatch_count;
  int               idle_cycles;
  int               burst_left;

  contiguous_time_slot_reserver dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .req  (req),
    .busy (busy),
    .done (done),
    .rsp  (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic ctsr_rsp_t fit_and_claim(input ctsr_req_t item);
    ctsr_rsp_t res;
    int        run_len;
    int        base;
    int        i;
    bit        hit;
    res     = '0;
    run_len = 0;
    base    = 0;
    hit     = 1'b0;
    if (item.duration != '0) begin
      for (i = int'(item.earliest_slot); i < SLOT_COUNT && !hit; i++) begin
        if (owner_map[i] == '0) begin
          run_len++;
          if (run_len == int'(item.duration)) begin
            base = i + 1 - run_len;
            hit  = 1'b1;
          end
        end else begin
          run_len = 0;
        end
      end
    end
    if (hit) begin
      res.found      = 1'b1;
      res.start_slot = base[START_W-1:0];
      if (item.req_type == REQ_RESERVE) begin
        for (i = base; i < base + int'(item.duration); i++)
          owner_map[i] = item.task_id[TASK_ID_BITS-1:0];
        res.end_slot = END_W'(base + int'(item.duration));
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $time, field, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    ctsr_rsp_t want;
    if (rst) begin
      idle_cycles <= 0;
      fit_head = 0;
      fit_tail = 0;
    end else begin
      if (done) begin
        if (fit_tail == fit_head) begin
          report_mismatch("unexpected result, start_slot", 16'(rsp.start_slot), 16'd0);
        end else begin
          want = fit_ring[fit_head % FIT_DEPTH];
          fit_head++;
          if (rsp.found !== want.found)
            report_mismatch("found", 16'(rsp.found), 16'(want.found));
          if (rsp.start_slot !== want.start_slot)
            report_mismatch("start_slot", 16'(rsp.start_slot), 16'(want.start_slot));
          if (rsp.end_slot !== want.end_slot)
            report_mismatch("end_slot", 16'(rsp.end_slot), 16'(want.end_slot));
        end
      end
      if (start && !busy) begin
        fit_ring[fit_tail % FIT_DEPTH] = fit_and_claim(req);
        fit_tail++;
      end
      if (done || (start && !busy)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("contiguous_time_slot_reserver_tb NOT OK");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // start stays high on return; wait_drained lowers it
  task automatic send_item(input logic kind, input int tid, input int early,
                           input int dur);
    ctsr_req_t item;
    int        gap;
    item.req_type      = kind;
    item.task_id       = tid[TID_W-1:0];
    item.earliest_slot = early[EARLY_W-1:0];
    item.duration      = dur[DUR_W-1:0];
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 40)
                                               : $urandom_range(1, 8);
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req   <= item;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (fit_tail != fit_head);
  endtask

  task automatic test_empty_table();
    send_item(REQ_PROBE, 1, 0, 1);
    send_item(REQ_PROBE, 1023, 0, 1024);
    send_item(REQ_PROBE, 5, 1023, 1);
    send_item(REQ_PROBE, 5, 1023, 2);
    wait_drained();
  endtask

  task automatic test_zero_duration();
    send_item(REQ_RESERVE, 1023, 0, 0);
    send_item(REQ_PROBE, 3, 5, 0);
    wait_drained();
  endtask

  task automatic test_oversize_runs();
    send_item(REQ_PROBE, 2, 0, 1025);
    send_item(REQ_RESERVE, 'h155, 0, 2047);
    send_item(REQ_RESERVE, 7, 1000, 100);
    wait_drained();
  endtask

  task automatic test_free_owner();
    send_item(REQ_RESERVE, 0, 0, 1024);
    send_item(REQ_PROBE, 9, 0, 1024);
    wait_drained();
  endtask

  task automatic test_table_edges();
    send_item(REQ_RESERVE, 1023, 1023, 1);
    send_item(REQ_PROBE, 4, 1020, 4);
    send_item(REQ_PROBE, 4, 1020, 3);
    send_item(REQ_RESERVE, 1, 0, 1);
    send_item(REQ_PROBE, 4, 0, 1);
    wait_drained();
  endtask

  task automatic test_fragmented_scan();
    send_item(REQ_RESERVE, 'h2AA, 5, 3);
    send_item(REQ_PROBE, 6, 3, 4);
    send_item(REQ_RESERVE, 'h155, 2, 2);
    send_item(REQ_PROBE, 6, 0, 3);
    send_item(REQ_RESERVE, 'h3FF, 0, 1);
    send_item(REQ_RESERVE, 512, 0, 1);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int count);
    int   n;
    int   pick;
    int   tid;
    int   early;
    int   dur;
    logic kind;
    for (n = 0; n < count; n++) begin
      pick  = $urandom_range(0, 99);
      kind  = ($urandom_range(0, 9) < 6) ? REQ_RESERVE : REQ_PROBE;
      tid   = ($urandom_range(0, 49) == 0) ? 0 : $urandom_range(1, 1023);
      early = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 63)
                                          : $urandom_range(0, 1023);
      if (pick < 4)
        dur = 0;
      else if (pick < 8)
        dur = $urandom_range(1025, 2047);
      else if (pick < 10)
        dur = $urandom_range(0, 2047);
      else if (pick < 20)
        dur = $urandom_range(9, 96);
      else
        dur = $urandom_range(1, 8);
      send_item(kind, tid, early, dur);
    end
    wait_drained();
  endtask

  initial begin
    int i;
    for (i = 0; i < SLOT_COUNT; i++) owner_map[i] = '0;
    mismatch_count = 0;
    burst_left     = 0;
    rst   = 1'b1;
    start = 1'b0;
    req   = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_zero_duration();
    test_oversize_runs();
    test_free_owner();
    test_table_edges();
    test_fragmented_scan();
    test_random_traffic(270);

    repeat (2 * SLOT_COUNT + 8) @(posedge clk);
    if (mismatch_count == 0)
      $display("contiguous_time_slot_reserver_tb OK");
    else
      $display("contiguous_time_slot_reserver_tb NOT OK");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/ctsr_pkg.sv
hw/rtl/ctsr_slot_ram.sv
hw/rtl/ctsr_run_unit.sv
hw/rtl/contiguous_time_slot_reserver.sv
tb/contiguous_time_slot_reserver_tb.sv
